// File: rtl/neutrino_pz_from_w_mass_top_defines.svh
// Assertion macros shared by the neutrino pz block.
`ifndef NEUTRINO_PZ_FROM_W_MASS_TOP_DEFINES_SVH
`define NEUTRINO_PZ_FROM_W_MASS_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled during reset.
`define NPPZ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled during reset.
`define NPPZ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nppz_pkg.sv
// Types and constants of the neutrino pz block.
`timescale 1ns / 1ps
package nppz_pkg;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_COMPLEX = 2'd1,
        KIND_DEGEN   = 2'd2,
        KIND_SAT     = 2'd3
    } t_kind;

    // Word index of the mass register (paddr bit 2).
    localparam logic REG_W_MASS = 1'b0;

    // 80.4 GeV in 1/256 GeV units.
    localparam int W_MASS_RESET = 20582;

    // Sign and case flags that ride along with the divider.
    typedef struct packed {
        logic neg;
        logic cplx;
        logic degen;
    } t_side;

endpackage

// File: rtl/nppz_dly.sv
// Fixed-length delay line for side data of the pipeline.
`timescale 1ns / 1ps
module nppz_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

// File: rtl/nppz_smul.sv
// Two-stage signed multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module nppz_smul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic signed [HA-1:0]   w_ah;
    logic signed [LA:0]     w_al;
    logic signed [HB-1:0]   w_bh;
    logic signed [LB:0]     w_bl;
    logic signed [HA+HB-1:0]   r_hh;
    logic signed [HA+LB:0]     r_hl;
    logic signed [LA+HB:0]     r_lh;
    logic signed [LA+LB+1:0]   r_ll;

    // Upper halves keep the sign, lower halves are plain magnitudes.
    assign w_ah = i_a[AW-1:LA];
    assign w_al = $signed({1'b0, i_a[LA-1:0]});
    assign w_bh = i_b[BW-1:LB];
    assign w_bl = $signed({1'b0, i_b[LB-1:0]});

    always_ff @(posedge i_clk) begin
        r_hh <= w_ah * w_bh;
        r_hl <= w_ah * w_bl;
        r_lh <= w_al * w_bh;
        r_ll <= w_al * w_bl;
        o_p  <= (PW'(r_hh) <<< (LA + LB)) + (PW'(r_hl) <<< LA)
              + (PW'(r_lh) <<< LB) + PW'(r_ll);
    end

endmodule

// File: rtl/nppz_sqrt.sv
// Pipelined integer floor square root, one root bit per stage.
`timescale 1ns / 1ps
module nppz_sqrt #(
    parameter int ROOT_W = 49
) (
    input  logic                  i_clk,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [RAD_W-1:0]  w_rad_in;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        // The remainder stays below 2*root+1, so its top two bits are zero.
        assign w_cur   = {w_rem_in[REM_W-3:0], w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (w_cur >= w_trial) begin
                r_rem[s]  <= w_cur - w_trial;
                r_root[s] <= {w_root_in[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[s]  <= w_cur;
                r_root[s] <= {w_root_in[ROOT_W-2:0], 1'b0};
            end
            r_rad[s] <= {w_rad_in[RAD_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// File: rtl/nppz_div.sv
// Pipelined restoring divider with an overflow flag, one quotient bit per stage.
`timescale 1ns / 1ps
module nppz_div #(
    parameter int NUM_W = 76,
    parameter int DEN_W = 49,
    parameter int QB    = 25
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QB-1:0]    o_quo,
    output logic             o_ovf
);

    logic [DEN_W-1:0] r_rem [QB+1];
    logic [QB-1:0]    r_low [QB+1];
    logic [DEN_W-1:0] r_den [QB+1];
    logic [QB-1:0]    r_quo [QB+1];
    logic             r_ovf [QB+1];
    logic             w_ovf;

    // A quotient that needs more than QB bits is flagged; its bits are then meaningless.
    assign w_ovf = i_num >= NUM_W'({i_den, QB'(0)});

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= w_ovf;
        r_rem[0] <= w_ovf ? '0 : i_num[QB +: DEN_W];
        r_low[0] <= i_num[QB-1:0];
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar j = 1; j <= QB; j++) begin : g_stage
        logic [DEN_W:0] w_cur;
        assign w_cur = {r_rem[j-1], r_low[j-1][QB-1]};

        always_ff @(posedge i_clk) begin
            if (w_cur >= {1'b0, r_den[j-1]}) begin
                r_rem[j] <= DEN_W'(w_cur - {1'b0, r_den[j-1]});
                r_quo[j] <= {r_quo[j-1][QB-2:0], 1'b1};
            end else begin
                r_rem[j] <= w_cur[DEN_W-1:0];
                r_quo[j] <= {r_quo[j-1][QB-2:0], 1'b0};
            end
            r_low[j] <= {r_low[j-1][QB-2:0], 1'b0};
            r_den[j] <= r_den[j-1];
            r_ovf[j] <= r_ovf[j-1];
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];

endmodule

// File: rtl/neutrino_pz_from_w_mass_top.sv
// Top level of the neutrino pz solver under a W-mass constraint.
`timescale 1ns / 1ps
`include "neutrino_pz_from_w_mass_top_defines.svh"
//
// Channel   Direction  Handshake                    Payload
// --------  ---------  ---------------------------  ----------------------------------
// event     in         start && !busy               i_lep_*, i_met_px, i_met_py
// result    out        o_strobe (one cycle)         o_nu_pz, o_solution_kind
// config    in/out     psel penable pwrite pready   paddr, pwdata, prdata (w_mass)
//
// An event beat is taken in every cycle; busy is never raised.
// Each result strobe follows its start beat through the full pipeline, whose length is set
// by the square root, which resolves one root bit per stage, and the divider, which
// resolves one quotient bit per stage.
// Reset is synchronous and active low; it clears the valid pipeline and reloads
// w_mass with 80.4 GeV. The receiver takes every strobe, so nothing stalls.
module neutrino_pz_from_w_mass_top #(
    parameter int MOM_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic signed [MOM_WIDTH-1:0] i_lep_px,
    input  logic signed [MOM_WIDTH-1:0] i_lep_py,
    input  logic signed [MOM_WIDTH-1:0] i_lep_pz,
    input  logic [MOM_WIDTH-2:0]        i_lep_energy,
    input  logic [MOM_WIDTH-2:0]        i_lep_mass,
    input  logic signed [MOM_WIDTH-1:0] i_met_px,
    input  logic signed [MOM_WIDTH-1:0] i_met_py,
    output logic                        o_strobe,
    output logic signed [MOM_WIDTH-1:0] o_nu_pz,
    output logic [1:0]                  o_solution_kind
);

    localparam int W     = MOM_WIDTH;
    localparam int P_W   = 2 * W;          // one product of two momenta
    localparam int A_W   = 2 * W + 2;      // a = mW^2 - m^2 + 2 pT.met
    localparam int AP_W  = 2 * W;          // A' = E^2 - pz^2
    localparam int PT_W  = 2 * W + 1;      // met pT squared, with sign bit
    localparam int Q_W   = 4 * W + 4;      // Q = a^2 - 4 A' pT^2
    localparam int QM_W  = 4 * W + 2;      // nonnegative Q
    localparam int R_W   = 2 * W + 1;      // floor sqrt of Q
    localparam int AZ_W  = A_W + W;        // a * pz
    localparam int T_W   = W + R_W + 1;    // E * sqrt(Q)
    localparam int N_W   = 3 * W + 3;      // numerator
    localparam int NM_W  = 3 * W + 2;      // numerator magnitude
    localparam int DM_W  = 2 * W;          // |2 A'|
    localparam int NUM_W = 3 * W + 4;      // 2|n| + |d|
    localparam int D2_W  = 2 * W + 1;      // 2|d|
    localparam int QB    = W + 1;          // quotient bits kept
    localparam int LAT   = 13 + R_W + QB;  // start beat to strobe

    localparam logic signed [W-1:0] PZ_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] PZ_MIN = {1'b1, {(W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic [W-2:0] r_w_mass;
    logic         w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_mass <= (W-1)'(nppz_pkg::W_MASS_RESET);
        end else if (w_wr && paddr[2] == nppz_pkg::REG_W_MASS) begin
            r_w_mass <= pwdata[W-2:0];
        end
    end

    always_comb begin
        if (paddr[2] == nppz_pkg::REG_W_MASS) begin
            prdata = 32'(r_w_mass);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Valid pipeline: one bit per register stage of the datapath.
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input capture. Stage 2: all momentum products.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r1_lpx, r1_lpy, r1_lpz, r1_mpx, r1_mpy;
    logic [W-2:0]        r1_en, r1_lm, r1_mw;
    logic signed [P_W-1:0] r2_pxx, r2_pyy, r2_mw2, r2_m2, r2_e2, r2_pz2, r2_mx2, r2_my2;
    logic signed [W-1:0] r2_pz;
    logic [W-2:0]        r2_en;

    always_ff @(posedge i_clk) begin
        r1_lpx <= i_lep_px;
        r1_lpy <= i_lep_py;
        r1_lpz <= i_lep_pz;
        r1_en  <= i_lep_energy;
        r1_lm  <= i_lep_mass;
        r1_mpx <= i_met_px;
        r1_mpy <= i_met_py;
        r1_mw  <= r_w_mass;

        r2_pxx <= r1_lpx * r1_mpx;
        r2_pyy <= r1_lpy * r1_mpy;
        r2_mw2 <= $signed({1'b0, r1_mw}) * $signed({1'b0, r1_mw});
        r2_m2  <= $signed({1'b0, r1_lm}) * $signed({1'b0, r1_lm});
        r2_e2  <= $signed({1'b0, r1_en}) * $signed({1'b0, r1_en});
        r2_pz2 <= r1_lpz * r1_lpz;
        r2_mx2 <= r1_mpx * r1_mpx;
        r2_my2 <= r1_mpy * r1_mpy;
        r2_pz  <= r1_lpz;
        r2_en  <= r1_en;
    end

    // ------------------------------------------------------------------
    // Stage 3: the quadratic's building blocks a, A' and pT^2.
    // ------------------------------------------------------------------
    logic signed [A_W-1:0]  r3_a;
    logic signed [AP_W-1:0] r3_ap;
    logic signed [PT_W-1:0] r3_pt2;
    logic signed [W-1:0]    r3_pz;
    logic [W-2:0]           r3_en;

    always_ff @(posedge i_clk) begin
        r3_a   <= A_W'(r2_mw2) - A_W'(r2_m2) + ((A_W'(r2_pxx) + A_W'(r2_pyy)) <<< 1);
        r3_ap  <= AP_W'(r2_e2) - AP_W'(r2_pz2);
        r3_pt2 <= PT_W'(r2_mx2) + PT_W'(r2_my2);
        r3_pz  <= r2_pz;
        r3_en  <= r2_en;
    end

    // ------------------------------------------------------------------
    // Stages 4-5: the wide products a^2, A' pT^2 and a pz.
    // ------------------------------------------------------------------
    logic signed [2*A_W-1:0]     w_aa;
    logic signed [AP_W+PT_W-1:0] w_appt;
    logic signed [AZ_W-1:0]      w_apz;
    logic signed [AP_W-1:0]      w5_ap;
    logic [W-2:0]                w5_en;

    nppz_smul #(.AW(A_W), .BW(A_W)) u_mul_aa (
        .i_clk (i_clk), .i_a (r3_a), .i_b (r3_a), .o_p (w_aa)
    );

    nppz_smul #(.AW(AP_W), .BW(PT_W)) u_mul_appt (
        .i_clk (i_clk), .i_a (r3_ap), .i_b (r3_pt2), .o_p (w_appt)
    );

    nppz_smul #(.AW(A_W), .BW(W)) u_mul_apz (
        .i_clk (i_clk), .i_a (r3_a), .i_b (r3_pz), .o_p (w_apz)
    );

    nppz_dly #(.WIDTH(AP_W + W - 1), .DEPTH(2)) u_dly_s5 (
        .i_clk (i_clk), .i_d ({r3_ap, r3_en}), .o_q ({w5_ap, w5_en})
    );

    // ------------------------------------------------------------------
    // Stage 6: Q = a^2 - 4 A' pT^2. A negative Q feeds zero to the root.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]  w_q;
    logic [QM_W-1:0]        r6_qmag;
    logic                   r6_qneg;
    logic signed [AZ_W-1:0] r6_apz;
    logic signed [AP_W-1:0] r6_ap;
    logic [W-2:0]           r6_en;

    assign w_q = Q_W'(w_aa) - (Q_W'(w_appt) <<< 2);

    always_ff @(posedge i_clk) begin
        r6_qneg <= w_q[Q_W-1];
        r6_qmag <= w_q[Q_W-1] ? '0 : w_q[QM_W-1:0];
        r6_apz  <= w_apz;
        r6_ap   <= w5_ap;
        r6_en   <= w5_en;
    end

    // ------------------------------------------------------------------
    // Square root, then t = E * sqrt(Q).
    // ------------------------------------------------------------------
    logic [R_W-1:0]         w_root;
    logic signed [AZ_W-1:0] w7_apz;
    logic signed [AP_W-1:0] w7_ap;
    logic [W-2:0]           w7_en;
    logic                   w7_qneg;
    logic signed [T_W-1:0]  w_t;
    logic signed [AZ_W-1:0] w8_apz;
    logic signed [AP_W-1:0] w8_ap;
    logic                   w8_qneg;
    logic                   w8_ezero;

    nppz_sqrt #(.ROOT_W(R_W)) u_sqrt (
        .i_clk (i_clk), .i_rad (r6_qmag), .o_root (w_root)
    );

    nppz_dly #(.WIDTH(AZ_W + AP_W + W), .DEPTH(R_W)) u_dly_root (
        .i_clk (i_clk),
        .i_d   ({r6_apz, r6_ap, r6_en, r6_qneg}),
        .o_q   ({w7_apz, w7_ap, w7_en, w7_qneg})
    );

    nppz_smul #(.AW(W), .BW(R_W + 1)) u_mul_t (
        .i_clk (i_clk),
        .i_a   ($signed({1'b0, w7_en})),
        .i_b   ($signed({1'b0, w_root})),
        .o_p   (w_t)
    );

    nppz_dly #(.WIDTH(AZ_W + AP_W + 2), .DEPTH(2)) u_dly_t (
        .i_clk (i_clk),
        .i_d   ({w7_apz, w7_ap, w7_qneg, w7_en == '0}),
        .o_q   ({w8_apz, w8_ap, w8_qneg, w8_ezero})
    );

    // ------------------------------------------------------------------
    // Numerator. For real roots the smaller magnitude is
    // sign(a pz) * (|a pz| - E sqrt(Q)); complex roots keep a pz alone.
    // ------------------------------------------------------------------
    logic                   w_cplx;
    logic signed [N_W-1:0]  w_n;
    logic signed [N_W-1:0]  r9_n;
    logic signed [AP_W-1:0] r9_ap;
    logic                   r9_cplx;
    logic                   r9_degen;

    assign w_cplx = w8_qneg & ~w8_ezero;

    always_comb begin
        if (w_cplx) begin
            w_n = N_W'(w8_apz);
        end else if (w8_apz[AZ_W-1]) begin
            w_n = N_W'(w8_apz) + N_W'(w_t);
        end else begin
            w_n = N_W'(w8_apz) - N_W'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        r9_n     <= w_n;
        r9_ap    <= w8_ap;
        r9_cplx  <= w_cplx;
        r9_degen <= (w8_ap == '0);
    end

    // ------------------------------------------------------------------
    // Magnitudes, then the rounding numerator 2|n|+|d| over 2|d|.
    // ------------------------------------------------------------------
    logic signed [N_W-1:0]  w_nabs;
    logic [AP_W-1:0]        w_apabs;
    logic [NM_W-1:0]        r10_nmag;
    logic [DM_W-1:0]        r10_dmag;
    nppz_pkg::t_side        r10_side;
    logic [NUM_W-1:0]       r11_num;
    logic [D2_W-1:0]        r11_den;
    nppz_pkg::t_side        r11_side;

    assign w_nabs  = r9_n[N_W-1] ? -r9_n : r9_n;
    assign w_apabs = r9_ap[AP_W-1] ? -r9_ap : r9_ap;

    always_ff @(posedge i_clk) begin
        r10_nmag       <= NM_W'(w_nabs);
        r10_dmag       <= {w_apabs[DM_W-2:0], 1'b0};
        r10_side.neg   <= r9_n[N_W-1] ^ r9_ap[AP_W-1];
        r10_side.cplx  <= r9_cplx;
        r10_side.degen <= r9_degen;

        r11_num  <= NUM_W'({r10_nmag, 1'b0}) + NUM_W'(r10_dmag);
        r11_den  <= {r10_dmag, 1'b0};
        r11_side <= r10_side;
    end

    // ------------------------------------------------------------------
    // Divider and saturation.
    // ------------------------------------------------------------------
    logic [QB-1:0]       w_quo;
    logic                w_ovf;
    nppz_pkg::t_side     w_side;
    logic                w_sat;
    logic signed [W-1:0] w_pz;
    nppz_pkg::t_kind     w_kind;
    logic signed [W-1:0] r_nu_pz;
    nppz_pkg::t_kind     r_kind;

    nppz_div #(.NUM_W(NUM_W), .DEN_W(D2_W), .QB(QB)) u_div (
        .i_clk (i_clk), .i_num (r11_num), .i_den (r11_den),
        .o_quo (w_quo), .o_ovf (w_ovf)
    );

    nppz_dly #(.WIDTH($bits(nppz_pkg::t_side)), .DEPTH(QB + 1)) u_dly_div (
        .i_clk (i_clk), .i_d (r11_side), .o_q (w_side)
    );

    // A negative result may reach 2^(W-1); a positive one stops one below.
    always_comb begin
        if (w_side.neg) begin
            w_sat = w_ovf | w_quo[QB-1] | (w_quo[QB-2] & (|w_quo[QB-3:0]));
        end else begin
            w_sat = w_ovf | w_quo[QB-1] | w_quo[QB-2];
        end

        if (w_side.degen) begin
            w_pz   = '0;
            w_kind = nppz_pkg::KIND_DEGEN;
        end else if (w_sat) begin
            w_pz   = w_side.neg ? PZ_MIN : PZ_MAX;
            w_kind = nppz_pkg::KIND_SAT;
        end else begin
            w_pz   = w_side.neg ? -$signed(w_quo[W-1:0]) : $signed(w_quo[W-1:0]);
            w_kind = w_side.cplx ? nppz_pkg::KIND_COMPLEX : nppz_pkg::KIND_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nu_pz <= w_pz;
        r_kind  <= w_kind;
    end

    assign o_strobe        = r_vld[LAT-1];
    assign o_nu_pz         = r_nu_pz;
    assign o_solution_kind = r_kind;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NPPZ_ASSERT_IMP(a_degen_zero,
        o_strobe && o_solution_kind == nppz_pkg::KIND_DEGEN, o_nu_pz == '0,
        "degenerate result carries a nonzero pz")
    `NPPZ_ASSERT_IMP(a_sat_end,
        o_strobe && o_solution_kind == nppz_pkg::KIND_SAT,
        o_nu_pz == PZ_MAX || o_nu_pz == PZ_MIN,
        "saturated result is not at a range end")
    `NPPZ_ASSERT_IMP(a_strobe_src, o_strobe, $past(start && !busy, LAT),
        "result strobe without a matching start beat")
    `NPPZ_ASSERT_NXT(a_cfg_write, w_wr && paddr[2] == nppz_pkg::REG_W_MASS,
        r_w_mass == $past(pwdata[W-2:0]), "mass register missed a write")

endmodule

// File: test/neutrino_pz_from_w_mass_checker.sv
// Checker that predicts and compares neutrino pz results.
`timescale 1ns / 1ps
module neutrino_pz_from_w_mass_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic signed [23:0] lep_px,
    input  logic signed [23:0] lep_py,
    input  logic signed [23:0] lep_pz,
    input  logic [22:0]        lep_energy,
    input  logic [22:0]        lep_mass,
    input  logic signed [23:0] met_px,
    input  logic signed [23:0] met_py,
    input  logic               strobe,
    input  logic signed [23:0] nu_pz,
    input  logic [1:0]         solution_kind,
    output int                 fails,
    output int                 pending
);

    typedef logic signed [199:0] t_wide;
    typedef logic [199:0] t_mag;

    typedef struct {
        logic signed [23:0] pz;
        nppz_pkg::t_kind    kind;
    } t_pz_result;

    t_pz_result pz_expected[$];
    logic [22:0] mass_shadow;

    initial begin
        fails = 0;
        pending = 0;
    end

    function automatic t_mag floor_sqrt(t_mag q);
        t_mag r;
        t_mag t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r;
            t[b] = 1'b1;
            if (t * t <= q) r = t;
        end
        return r;
    endfunction

    // Solves the W-mass quadratic exactly and rounds the chosen root.
    function automatic t_pz_result solve_pz(logic [22:0] mw_in);
        t_pz_result res;
        t_wide lpx, lpy, lpz, en, lm, mpx, mpy, mw;
        t_wide a, ap, apz, pt2, q, n, den, s;
        t_mag nm, dm, quo;
        lpx = lep_px;
        lpy = lep_py;
        lpz = lep_pz;
        mpx = met_px;
        mpy = met_py;
        en  = t_wide'({1'b0, lep_energy});
        lm  = t_wide'({1'b0, lep_mass});
        mw  = t_wide'({1'b0, mw_in});
        a  = mw * mw - lm * lm + 2 * (lpx * mpx + lpy * mpy);
        ap = en * en - lpz * lpz;
        if (ap == 0) begin
            res.pz = '0;
            res.kind = nppz_pkg::KIND_DEGEN;
            return res;
        end
        apz = a * lpz;
        pt2 = mpx * mpx + mpy * mpy;
        q   = a * a - 4 * ap * pt2;
        if (en == 0 || q >= 0) begin
            // Real roots: take the one closer to zero.
            s = (q < 0) ? t_wide'(0) : t_wide'(floor_sqrt(t_mag'(q)));
            n = (apz < 0 ? -apz : apz) - en * s;
            if (apz < 0) n = -n;
            res.kind = nppz_pkg::KIND_REAL;
        end else begin
            n = apz;
            res.kind = nppz_pkg::KIND_COMPLEX;
        end
        den = 2 * ap;
        nm = t_mag'(n < 0 ? -n : n);
        dm = t_mag'(den < 0 ? -den : den);
        quo = (2 * nm + dm) / (2 * dm);
        if ((n < 0) != (den < 0)) begin
            if (quo > t_mag'(24'h800000)) begin
                res.pz = 24'sh800000;
                res.kind = nppz_pkg::KIND_SAT;
            end else begin
                res.pz = -quo[23:0];
            end
        end else begin
            if (quo > t_mag'(24'h7FFFFF)) begin
                res.pz = 24'sh7FFFFF;
                res.kind = nppz_pkg::KIND_SAT;
            end else begin
                res.pz = quo[23:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_pz_result want;
        if (!i_rst_n) begin
            mass_shadow = 23'(nppz_pkg::W_MASS_RESET);
            pz_expected.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == nppz_pkg::REG_W_MASS)
                mass_shadow = pwdata[22:0];
            if (start && !busy)
                pz_expected.push_back(solve_pz(mass_shadow));
            if (strobe) begin
                if (pz_expected.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = pz_expected.pop_front();
                    if (nu_pz !== want.pz)
                        report_mismatch($sformatf("nu_pz %0d, expected %0d", nu_pz, want.pz));
                    if (solution_kind !== want.kind)
                        report_mismatch($sformatf("solution_kind %0d, expected %0d",
                                                  solution_kind, want.kind));
                end
            end
        end
        pending = pz_expected.size();
    end

endmodule

// File: test/neutrino_pz_from_w_mass_top_tb.sv
// Testbench top that drives events and mass writes into the neutrino pz block.
`timescale 1ns / 1ps
module neutrino_pz_from_w_mass_top_tb;

    // Address of the mass register and of an unused word that must be ignored.
    localparam logic [2:0] ADDR_W_MASS = {nppz_pkg::REG_W_MASS, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = {~nppz_pkg::REG_W_MASS, 2'b00};
    // This margin covers the pipeline depth from start beat to result with room to spare.
    localparam int DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic signed [23:0] lep_px = '0, lep_py = '0, lep_pz = '0;
    logic [22:0] lep_energy = '0, lep_mass = '0;
    logic signed [23:0] met_px = '0, met_py = '0;

    logic busy, pready, o_strobe;
    logic [31:0] prdata;
    logic signed [23:0] o_nu_pz;
    logic [1:0] o_solution_kind;
    logic busy_seen;
    int fails, pending;
    bit calm;

    always #1 i_clk = ~i_clk;

    // Busy is sampled mid-cycle so the acceptance test sees the settled value.
    always @(negedge i_clk) busy_seen = busy;

    neutrino_pz_from_w_mass_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_lep_px(lep_px), .i_lep_py(lep_py), .i_lep_pz(lep_pz),
        .i_lep_energy(lep_energy), .i_lep_mass(lep_mass),
        .i_met_px(met_px), .i_met_py(met_py),
        .o_strobe(o_strobe), .o_nu_pz(o_nu_pz), .o_solution_kind(o_solution_kind)
    );

    neutrino_pz_from_w_mass_checker pz_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .lep_px(lep_px), .lep_py(lep_py), .lep_pz(lep_pz),
        .lep_energy(lep_energy), .lep_mass(lep_mass),
        .met_px(met_px), .met_py(met_py),
        .strobe(o_strobe), .nu_pz(o_nu_pz), .solution_kind(o_solution_kind),
        .fails(fails), .pending(pending)
    );

    // Setup cycle, then access cycle; the write lands on the edge with pready high.
    task automatic mass_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Places one event beat on the bus and holds it until the block takes it.
    // Start stays high afterward unless a random idle burst follows.
    task automatic send_event(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                              logic [22:0] e, logic [22:0] m,
                              logic [23:0] mx, logic [23:0] my);
        int gap;
        lep_px <= px;
        lep_py <= py;
        lep_pz <= pz;
        lep_energy <= e;
        lep_mass <= m;
        met_px <= mx;
        met_py <= my;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy_seen) @(posedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every expected result has come back, plus the pipeline depth,
    // so the mass register can be changed with nothing in flight.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random events: mostly physical leptons of moderate size, some on the
    // degenerate line, some with zero energy, the rest raw noise over all bits.
    task automatic random_event();
        logic [23:0] px, py, pz, mx, my;
        logic [22:0] e, m;
        int pick;
        pick = $urandom_range(0, 99);
        px = 24'($urandom);
        py = 24'($urandom);
        pz = 24'($urandom);
        mx = 24'($urandom);
        my = 24'($urandom);
        e = 23'($urandom);
        m = 23'($urandom);
        if (pick < 65) begin
            px = 24'($signed(px[17:0]));
            py = 24'($signed(py[17:0]));
            pz = 24'($signed(pz[19:0]));
            mx = 24'($signed(mx[17:0]));
            my = 24'($signed(my[17:0]));
            m  = 23'(m[8:0]);
            // Energy at or above |pz| keeps the event physical.
            e  = 23'((pz[23] ? -$signed(pz) : $signed(pz))) + 23'(e[15:0]);
        end else if (pick < 75) begin
            pz = 24'($signed(pz[22:0]));
            e  = pz[23] ? 23'(-$signed(pz)) : pz[22:0];
        end else if (pick < 82) begin
            e = '0;
        end
        send_event(px, py, pz, e, m, mx, my);
    endtask

    initial begin
        int phase_items;
        calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events at the reset mass of 80.4 GeV.
        send_event(24'sd10000, 24'sd5000, 24'sd8000, 23'd12000, 23'd27, 24'sd9000, -24'sd3000);
        send_event(24'sd0, 24'sd0, 24'sd0, 23'd0, 23'd0, 24'sd0, 24'sd0);
        send_event(24'sd100, 24'sd0, 24'sd5000, 23'd5000, 23'd0, 24'sd100, 24'sd0);
        send_event(24'sd100, 24'sd0, -24'sd5000, 23'd5000, 23'd0, 24'sd100, 24'sd0);
        send_event(24'sd3000, 24'sd0, 24'sd4000, 23'd0, 23'd0, 24'sd2000, 24'sd0);
        send_event(24'sd20000, 24'sd0, 24'sd2000, 23'd20100, 23'd0, -24'sd40000, 24'sd0);
        send_event(24'sd20000, -24'sd1000, 24'sd2000, 23'd20100, 23'd0, 24'sd40000, 24'sd500);
        send_event(24'sd1, 24'sd0, 24'sd1000, 23'd1001, 23'd0, 24'sd0, 24'sd0);
        send_event(24'sd1, 24'sd0, -24'sd1000, 23'd1001, 23'd0, 24'sd0, 24'sd0);
        send_event(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                   24'sh7FFFFF, 24'sh7FFFFF);
        send_event(24'sh800000, 24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF,
                   24'sh800000, 24'sh800000);
        send_event(24'sh800000, 24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'd0,
                   24'sh7FFFFF, 24'sh800000);
        send_event(24'sd0, 24'sd0, 24'sh7FFFFF, 23'h7FFFFF, 23'd0, 24'sd0, 24'sd0);
        send_event(24'sd0, 24'sd0, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 24'sd0, 24'sd0);
        send_event(24'sd0, 24'sd0, -24'sd100, 23'd0, 23'h7FFFFF, 24'sd0, 24'sd0);
        send_event(24'sd5, 24'sd7, 24'sd1, 23'd2, 23'd1, 24'sd3, -24'sd9);
        send_event(24'sd0, 24'sd0, 24'sd300, 23'd299, 23'd0, 24'sh7FFFFF, 24'sd0);
        send_event(24'sd500, 24'sd0, 24'sd1, 23'd1, 23'd0, 24'sd0, 24'sd0);

        // Mass settings: zero, full scale, an ignored write, two random ones, then the reset mass.
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: mass_write(ADDR_W_MASS, 32'd0);
                1: mass_write(ADDR_W_MASS, 32'h007FFFFF);
                2: mass_write(ADDR_UNUSED, 32'd1234);
                3: mass_write(ADDR_W_MASS, 32'($urandom_range(0, 32767)));
                4: mass_write(ADDR_W_MASS, 32'($urandom));
                default: mass_write(ADDR_W_MASS, 32'(nppz_pkg::W_MASS_RESET));
            endcase
            // The last phase runs with no idling at all.
            calm = (phase == 5);
            phase_items = (phase == 5) ? 250 : 180;
            repeat (phase_items) random_event();
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
